### sv/hrlb_pkg.sv
`timescale 1ns / 1ps

package hrlb_pkg;

   localparam int LEVEL_WIDTH = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
   localparam int ITER_COUNT  = 4;
   localparam int ITER_WIDTH  = $clog2(ITER_COUNT);

   typedef logic [LEVEL_WIDTH-1:0] level_type;
   typedef level_type [2:0]        levels_type;
   typedef logic [1:0]             group_type;
   typedef logic [1:0]             axis_type;

   // face code 6 or 7
   localparam group_type GROUP_NONE = 2'd3;

   typedef struct packed {
      logic      mode;
      logic [2:0] cell_face;
      logic [2:0] nbr_face;
      logic [1:0] start_offset;
      logic      orient_flip;
      level_type cell_level_a;
      level_type cell_level_b;
      level_type cell_level_g;
      level_type nbr_level_a;
      level_type nbr_level_b;
      level_type nbr_level_g;
   } req_type;

   typedef struct packed {
      level_type new_cell_level_a;
      level_type new_cell_level_b;
      level_type new_cell_level_g;
      level_type new_nbr_level_a;
      level_type new_nbr_level_b;
      level_type new_nbr_level_g;
      logic      levels_changed;
   } rsp_type;

   // classified pair, levels already in the cell frame after the 2:1 rule
   typedef struct packed {
      logic       mode;
      group_type  cell_group;
      group_type  nbr_group;
      logic       swap;
      logic       faces_ok;
      levels_type cell_lv;
      levels_type nbr_lv;
      levels_type cell_orig;
      levels_type nbr_orig;
   } job_type;

   typedef struct packed {
      logic                 empty;
      logic                 full;
      logic [CNT_WIDTH-1:0] count;
   } queue_status_type;

   function automatic axis_type normal_axis(group_type g);
      case (g)
         2'd0:    return 2'd2;
         2'd1:    return 2'd0;
         2'd2:    return 2'd1;
         default: return 2'd2;
      endcase
   endfunction

   function automatic axis_type tan_first(group_type g);
      case (g)
         2'd0:    return 2'd0;
         2'd1:    return 2'd1;
         2'd2:    return 2'd0;
         default: return 2'd0;
      endcase
   endfunction

   function automatic axis_type tan_second(group_type g);
      case (g)
         2'd0:    return 2'd1;
         2'd1:    return 2'd2;
         2'd2:    return 2'd2;
         default: return 2'd1;
      endcase
   endfunction

   function automatic levels_type permute_frame(group_type dst, group_type src, logic swap,
                                                levels_type lv);
      levels_type r;
      level_type  p;
      level_type  q;
      p = lv[tan_first(src)];
      q = lv[tan_second(src)];
      r = lv;
      r[normal_axis(dst)] = lv[normal_axis(src)];
      r[tan_first(dst)]   = swap ? q : p;
      r[tan_second(dst)]  = swap ? p : q;
      return r;
   endfunction

endpackage

### sv/hrlb_channels.sv
`timescale 1ns / 1ps

interface hrlb_req_if;
   import hrlb_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface hrlb_rsp_if;
   import hrlb_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

### sv/hrlb_front.sv
`timescale 1ns / 1ps

module hrlb_front (
   hrlb_req_if.sink                  req_ch,
   input  hrlb_pkg::queue_status_type q_status,
   output logic                      push,
   output hrlb_pkg::job_type         push_job
);
   import hrlb_pkg::*;

   group_type  cg;
   group_type  ng;
   logic       swap;
   logic       faces_ok;
   levels_type c0;
   levels_type n0;
   levels_type c;
   levels_type n;

   assign req_ch.ready = !q_status.full;
   assign push         = req_ch.valid && !q_status.full;

   always_comb begin
      cg       = req_ch.payload.cell_face[2:1];
      ng       = req_ch.payload.nbr_face[2:1];
      swap     = req_ch.payload.start_offset[0] ^ req_ch.payload.orient_flip;
      faces_ok = (cg != GROUP_NONE) && (ng != GROUP_NONE);
      c0       = {req_ch.payload.cell_level_g, req_ch.payload.cell_level_b,
                  req_ch.payload.cell_level_a};
      n0       = {req_ch.payload.nbr_level_g, req_ch.payload.nbr_level_b,
                  req_ch.payload.nbr_level_a};
      c        = c0;
      n        = faces_ok ? permute_frame(cg, ng, swap, n0) : n0;
      // 2:1 rule per direction
      for (int i = 0; i < 3; i++) begin
         if ({1'b0, n[i]} > ({1'b0, c[i]} + 1'b1)) begin
            c[i] = n[i] - 1'b1;
         end else if (!req_ch.payload.mode && ({1'b0, c[i]} > ({1'b0, n[i]} + 1'b1))) begin
            n[i] = c[i] - 1'b1;
         end
      end
      push_job.mode       = req_ch.payload.mode;
      push_job.cell_group = cg;
      push_job.nbr_group  = ng;
      push_job.swap       = swap;
      push_job.faces_ok   = faces_ok;
      push_job.cell_lv    = c;
      push_job.nbr_lv     = n;
      push_job.cell_orig  = c0;
      push_job.nbr_orig   = n0;
   end

endmodule

### sv/hrlb_queue.sv
`timescale 1ns / 1ps

module hrlb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hrlb_pkg::job_type          push_job,
   input  logic                       pop,
   output hrlb_pkg::job_type          pop_job,
   output hrlb_pkg::queue_status_type status
);
   import hrlb_pkg::*;

   job_type              mem [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff;
   logic [PTR_WIDTH-1:0] wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff;
   logic [PTR_WIDTH-1:0] rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff;
   logic [CNT_WIDTH-1:0] count_in;

   function automatic logic [PTR_WIDTH-1:0] next_ptr(logic [PTR_WIDTH-1:0] p);
      return (p == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign pop_job      = mem[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign status.count = count_ff;

endmodule

### sv/hrlb_back.sv
`timescale 1ns / 1ps

module hrlb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  hrlb_pkg::queue_status_type q_status,
   input  hrlb_pkg::job_type          pop_job,
   output logic                       pop,
   hrlb_rsp_if.source                 rsp_ch
);
   import hrlb_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   state_type             state_ff;
   state_type             state_in;
   job_type               job_ff;
   job_type               job_in;
   level_type [3:0]       inc_ff;
   level_type [3:0]       inc_in;
   level_type             total_ff;
   level_type             total_in;
   logic [ITER_WIDTH-1:0] iter_ff;
   logic [ITER_WIDTH-1:0] iter_in;
   rsp_type               out_ff;
   rsp_type               out_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;

   logic       stop;
   level_type  least;
   logic       out_write;
   axis_type   px;
   axis_type   py;
   axis_type   jx;
   axis_type   jy;
   logic       cell_ok;
   levels_type c;
   levels_type n;
   levels_type nl;

   always_comb begin
      px = tan_first(pop_job.cell_group);
      py = tan_second(pop_job.cell_group);
      jx = tan_first(job_ff.cell_group);
      jy = tan_second(job_ff.cell_group);
      cell_ok = (job_ff.cell_group != GROUP_NONE);

      // conflict fixer step
      stop = !cell_ok
          || (inc_ff[0] == '0 && inc_ff[1] == '0) || (inc_ff[2] == '0 && inc_ff[3] == '0)
          || (inc_ff[0] == '0 && inc_ff[2] == '0) || (inc_ff[1] == '0 && inc_ff[3] == '0);
      least = '1;
      for (int i = 0; i < 4; i++) begin
         if (inc_ff[i] != '0 && inc_ff[i] < least) begin
            least = inc_ff[i];
         end
      end

      // finish: raise tangential levels, return neighbour to its frame
      c = job_ff.cell_lv;
      n = job_ff.nbr_lv;
      for (int i = 0; i < 3; i++) begin
         if (cell_ok && (2'(i) == jx || 2'(i) == jy)) begin
            if (c[i] < total_ff) begin
               c[i] = total_ff;
            end
            if (n[i] < total_ff) begin
               n[i] = total_ff;
            end
         end
      end
      if (job_ff.mode) begin
         nl = job_ff.nbr_orig;
      end else if (job_ff.faces_ok) begin
         nl = permute_frame(job_ff.nbr_group, job_ff.cell_group, job_ff.swap, n);
      end else begin
         nl = n;
      end

      out_write = !out_valid_ff || rsp_ch.ready;
      pop       = (state_ff == ST_IDLE) && !q_status.empty;

      state_in     = state_ff;
      job_in       = job_ff;
      inc_in       = inc_ff;
      total_in     = total_ff;
      iter_in      = iter_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               job_in    = pop_job;
               inc_in[0] = pop_job.cell_lv[px];
               inc_in[1] = pop_job.cell_lv[py];
               inc_in[2] = pop_job.nbr_lv[px];
               inc_in[3] = pop_job.nbr_lv[py];
               total_in  = '0;
               iter_in   = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            if (stop) begin
               state_in = ST_DONE;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  inc_in[i] = (inc_ff[i] > least) ? inc_ff[i] - least : '0;
               end
               total_in = total_ff + least;
               iter_in  = iter_ff + 1'b1;
               if (iter_ff == ITER_WIDTH'(ITER_COUNT - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_write) begin
               out_in.new_cell_level_a = c[0];
               out_in.new_cell_level_b = c[1];
               out_in.new_cell_level_g = c[2];
               out_in.new_nbr_level_a  = nl[0];
               out_in.new_nbr_level_b  = nl[1];
               out_in.new_nbr_level_g  = nl[2];
               out_in.levels_changed   = (c != job_ff.cell_orig) || (nl != job_ff.nbr_orig);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff   <= job_in;
      inc_ff   <= inc_in;
      total_ff <= total_in;
      iter_ff  <= iter_in;
      out_ff   <= out_in;
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_ff;

endmodule

### sv/hex_refinement_level_balance.sv
`timescale 1ns / 1ps

// Refinement-level balance for one pair of face-adjacent hex cells.
// req_ch carries one face pair per transfer (faces, offset, flip, both level
// triples); rsp_ch returns one transfer per request with the balanced cell
// levels, the neighbour levels in the neighbour frame and a change flag.
// The front end permutes the neighbour into the cell frame, applies the 2:1
// rule and writes the pair into a two-entry queue in the cycle it is taken.
// The back end runs the tangential conflict fixer one pass per cycle, up to
// four passes, then writes the output register.
// The back end takes the next pair from the queue only once it is idle again.
// Reset empties the queue, returns the back end to idle and clears
// rsp_ch.valid; the data registers are not cleared.
// A stalled receiver holds the result in the output register; the back end
// waits, the queue fills and req_ch.ready drops once both entries are held.
module hex_refinement_level_balance (
   input logic         clock,
   input logic         reset,
   hrlb_req_if.sink    req_ch,
   hrlb_rsp_if.source  rsp_ch
);
   import hrlb_pkg::*;

   logic             q_push;
   logic             q_pop;
   job_type          q_push_job;
   job_type          q_pop_job;
   queue_status_type q_status;

   hrlb_front u_front (
      .req_ch   (req_ch),
      .q_status (q_status),
      .push     (q_push),
      .push_job (q_push_job)
   );

   hrlb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .pop_job  (q_pop_job),
      .status   (q_status)
   );

   hrlb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_job  (q_pop_job),
      .pop      (q_pop),
      .rsp_ch   (rsp_ch)
   );

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= CNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> q_status.count == $past(q_status.count) + CNT_WIDTH'(1))
      else $error("queue count missed a push");
`endif

endmodule

### tb/tb_hex_refinement_level_balance.sv
`timescale 1ns / 1ps

module tb_hex_refinement_level_balance;
   import hrlb_pkg::*;

   localparam logic MODE_PAIR      = 1'b0;
   localparam logic MODE_ONE_SIDED = 1'b1;

   localparam logic [2:0] FACE_BOTTOM  = 3'd0;
   localparam logic [2:0] FACE_TOP     = 3'd1;
   localparam logic [2:0] FACE_LEFT    = 3'd2;
   localparam logic [2:0] FACE_RIGHT   = 3'd3;
   localparam logic [2:0] FACE_FRONT   = 3'd4;
   localparam logic [2:0] FACE_BACK    = 3'd5;
   localparam logic [2:0] FACE_VOID_LO = 3'd6;
   localparam logic [2:0] FACE_VOID_HI = 3'd7;

   // axis tables per face group, entry 0 at the right
   localparam bit [2:0][1:0] NORMAL_OF = {2'd1, 2'd0, 2'd2};
   localparam bit [2:0][1:0] TAN_A     = {2'd0, 2'd1, 2'd0};
   localparam bit [2:0][1:0] TAN_B     = {2'd2, 2'd2, 2'd1};
   localparam int NO_LEAST    = 1000;
   localparam int HOLD_CYCLES = 60;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 30;

   typedef bit [2:0][7:0] trio_type;
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_BUSY_LIGHT,
      RX_BUSY_HEAVY,
      RX_PERIODIC
   } rx_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrlb_req_if req_ch();
   hrlb_rsp_if rsp_ch();

   hex_refinement_level_balance i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   req_type pending_pairs[$];
   rsp_type balance_expect[$];
   int      queued_total    = 0;
   int      accepted_pairs  = 0;
   int      results_checked = 0;
   int      changed_count   = 0;
   int      one_sided_count = 0;
   int      void_face_count = 0;
   int      mismatch_count  = 0;
   int      hold_asks       = 0;
   int      hold_served     = 0;
   int      hold_left       = 0;
   int      stall_cycle     = 0;
   int      burst_left      = 0;
   int      gap_left        = 0;
   int      idle_cycles     = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // move levels from the frame of face group src into group dst
   function automatic trio_type reframe(int dst, int src, bit swp, trio_type lv);
      trio_type res;
      bit [7:0] p;
      bit [7:0] q;
      p = lv[TAN_A[src]];
      q = lv[TAN_B[src]];
      res = lv;
      res[NORMAL_OF[dst]] = lv[NORMAL_OF[src]];
      res[TAN_A[dst]] = swp ? q : p;
      res[TAN_B[dst]] = swp ? p : q;
      return res;
   endfunction

   // sum of least nonzero increments until a tangential pair runs dry, at most four rounds
   function automatic int conflict_floor(int a, int b, int c, int d);
      int inc[4];
      int total;
      int least;
      inc[0] = a;
      inc[1] = b;
      inc[2] = c;
      inc[3] = d;
      total = 0;
      for (int it = 0; it < 4; it++) begin
         if ((inc[0] == 0 && inc[1] == 0) || (inc[2] == 0 && inc[3] == 0) ||
             (inc[0] == 0 && inc[2] == 0) || (inc[1] == 0 && inc[3] == 0))
            break;
         least = NO_LEAST;
         for (int i = 0; i < 4; i++)
            if (inc[i] != 0 && inc[i] < least)
               least = inc[i];
         total += least;
         for (int i = 0; i < 4; i++)
            inc[i] = (inc[i] > least) ? inc[i] - least : 0;
      end
      return total;
   endfunction

   function automatic rsp_type balance_pair(req_type r);
      trio_type cell_lv;
      trio_type nbr;
      trio_type cell_in;
      trio_type nbr_in;
      trio_type nbr_out;
      int       cg;
      int       ng;
      int       x;
      int       y;
      int       floor_lv;
      bit       swp;
      bit       faces_ok;
      bit       changed;
      rsp_type  res;
      cg = int'(r.cell_face >> 1);
      ng = int'(r.nbr_face >> 1);
      faces_ok = (cg <= 2) && (ng <= 2);
      swp = r.start_offset[0] ^ r.orient_flip;
      cell_in = {8'(r.cell_level_g), 8'(r.cell_level_b), 8'(r.cell_level_a)};
      nbr_in  = {8'(r.nbr_level_g), 8'(r.nbr_level_b), 8'(r.nbr_level_a)};
      cell_lv = cell_in;
      nbr  = nbr_in;
      if (faces_ok)
         nbr = reframe(cg, ng, swp, nbr);
      for (int i = 0; i < 3; i++) begin
         if (nbr[i] > cell_lv[i] + 8'd1)
            cell_lv[i] = nbr[i] - 8'd1;
         else if (r.mode == MODE_PAIR && cell_lv[i] > nbr[i] + 8'd1)
            nbr[i] = cell_lv[i] - 8'd1;
      end
      if (cg <= 2) begin
         x = int'(TAN_A[cg]);
         y = int'(TAN_B[cg]);
         floor_lv = conflict_floor(cell_lv[x], cell_lv[y], nbr[x], nbr[y]);
         if (cell_lv[x] < floor_lv) cell_lv[x] = 8'(floor_lv);
         if (cell_lv[y] < floor_lv) cell_lv[y] = 8'(floor_lv);
         if (nbr[x] < floor_lv) nbr[x] = 8'(floor_lv);
         if (nbr[y] < floor_lv) nbr[y] = 8'(floor_lv);
      end
      if (r.mode == MODE_PAIR) begin
         nbr_out = faces_ok ? reframe(ng, cg, swp, nbr) : nbr;
      end else begin
         nbr_out = nbr_in;
      end
      changed = 1'b0;
      for (int i = 0; i < 3; i++) begin
         cell_lv[i] = cell_lv[i] & 8'hf;
         nbr_out[i] = nbr_out[i] & 8'hf;
         if (cell_lv[i] != cell_in[i] || nbr_out[i] != nbr_in[i])
            changed = 1'b1;
      end
      res.new_cell_level_a = cell_lv[0][3:0];
      res.new_cell_level_b = cell_lv[1][3:0];
      res.new_cell_level_g = cell_lv[2][3:0];
      res.new_nbr_level_a  = nbr_out[0][3:0];
      res.new_nbr_level_b  = nbr_out[1][3:0];
      res.new_nbr_level_g  = nbr_out[2][3:0];
      res.levels_changed   = changed;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= 20)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic queue_pair(logic m, logic [2:0] cf, logic [2:0] nf, logic [1:0] off,
                             logic fl, level_type ca, level_type cb, level_type cc,
                             level_type na, level_type nb, level_type nc);
      req_type r;
      r.mode = m;
      r.cell_face = cf;
      r.nbr_face = nf;
      r.start_offset = off;
      r.orient_flip = fl;
      r.cell_level_a = ca;
      r.cell_level_b = cb;
      r.cell_level_g = cc;
      r.nbr_level_a = na;
      r.nbr_level_b = nb;
      r.nbr_level_g = nc;
      pending_pairs.push_back(r);
      queued_total++;
   endtask

   task automatic queue_random_pair();
      level_type lv[6];
      int        style;
      int        base;
      logic [2:0] cf;
      logic [2:0] nf;
      style = $urandom_range(0, 2);
      base = $urandom_range(2, 13);
      for (int i = 0; i < 6; i++) begin
         case (style)
            0:       lv[i] = level_type'($urandom_range(0, 15));
            1:       lv[i] = level_type'(base + $urandom_range(0, 4) - 2);
            default: lv[i] = level_type'($urandom_range(0, 3));
         endcase
      end
      cf = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
      nf = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
      queue_pair(1'($urandom_range(0, 1)), cf, nf, 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), lv[0], lv[1], lv[2], lv[3], lv[4], lv[5]);
   endtask

   task automatic wait_drained();
      while (accepted_pairs != queued_total || balance_expect.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!(req_ch.valid && !req_ch.ready)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_pairs.size() > 0) begin
            req_ch.payload <= pending_pairs.pop_front();
            req_ch.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_cycle <= 0;
      end else begin
         stall_cycle <= stall_cycle + 1;
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (hold_served != hold_asks) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (rx_style_type'(stall_cycle[9:8]))
               RX_OPEN:       rsp_ch.ready <= 1'b1;
               RX_BUSY_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               RX_BUSY_HEAVY: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
               default:       rsp_ch.ready <= (stall_cycle % 5 != 0);
            endcase
         end
      end
   end

   // transfer monitor and checker
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            balance_expect.push_back(balance_pair(req_ch.payload));
            accepted_pairs++;
            if (req_ch.payload.mode == MODE_ONE_SIDED)
               one_sided_count++;
            if (req_ch.payload.cell_face >= FACE_VOID_LO ||
                req_ch.payload.nbr_face >= FACE_VOID_LO)
               void_face_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (balance_expect.size() == 0) begin
               report_mismatch("result with nothing pending", 1, 0);
            end else begin
               want = balance_expect.pop_front();
               results_checked++;
               if (want.levels_changed)
                  changed_count++;
               if (got.new_cell_level_a !== want.new_cell_level_a)
                  report_mismatch("new_cell_level_a", got.new_cell_level_a,
                                  want.new_cell_level_a);
               if (got.new_cell_level_b !== want.new_cell_level_b)
                  report_mismatch("new_cell_level_b", got.new_cell_level_b,
                                  want.new_cell_level_b);
               if (got.new_cell_level_g !== want.new_cell_level_g)
                  report_mismatch("new_cell_level_g", got.new_cell_level_g,
                                  want.new_cell_level_g);
               if (got.new_nbr_level_a !== want.new_nbr_level_a)
                  report_mismatch("new_nbr_level_a", got.new_nbr_level_a,
                                  want.new_nbr_level_a);
               if (got.new_nbr_level_b !== want.new_nbr_level_b)
                  report_mismatch("new_nbr_level_b", got.new_nbr_level_b,
                                  want.new_nbr_level_b);
               if (got.new_nbr_level_g !== want.new_nbr_level_g)
                  report_mismatch("new_nbr_level_g", got.new_nbr_level_g,
                                  want.new_nbr_level_g);
               if (got.levels_changed !== want.levels_changed)
                  report_mismatch("levels_changed", got.levels_changed,
                                  want.levels_changed);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                  IDLE_LIMIT, balance_expect.size());
         $display("tb_hex_refinement_level_balance failed");
         $finish;
      end
   end

   initial begin : stimulus
      int idx;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_pair(MODE_PAIR, FACE_BOTTOM, FACE_TOP, 2'd0, 1'b0, 0, 0, 0, 0, 0, 0);
      queue_pair(MODE_ONE_SIDED, FACE_BACK, FACE_FRONT, 2'd3, 1'b1,
                 15, 15, 15, 15, 15, 15);
      queue_pair(MODE_PAIR, FACE_BOTTOM, FACE_BOTTOM, 2'd0, 1'b0, 0, 0, 0, 15, 15, 15);
      queue_pair(MODE_PAIR, FACE_TOP, FACE_RIGHT, 2'd1, 1'b0, 15, 15, 15, 0, 0, 0);
      queue_pair(MODE_ONE_SIDED, FACE_TOP, FACE_RIGHT, 2'd1, 1'b0, 15, 15, 15, 0, 0, 0);
      queue_pair(MODE_ONE_SIDED, FACE_LEFT, FACE_FRONT, 2'd2, 1'b1, 0, 0, 0, 15, 15, 15);
      // unused face codes: no frame change, fixer skipped where the cell face is unused
      queue_pair(MODE_PAIR, FACE_VOID_LO, FACE_LEFT, 2'd1, 1'b1, 3, 9, 1, 12, 2, 6);
      queue_pair(MODE_PAIR, FACE_FRONT, FACE_VOID_HI, 2'd0, 1'b1, 3, 9, 1, 12, 2, 6);
      queue_pair(MODE_ONE_SIDED, FACE_VOID_HI, FACE_VOID_LO, 2'd2, 1'b0,
                 14, 0, 7, 1, 15, 3);
      // tangential conflicts needing several fixer passes
      queue_pair(MODE_PAIR, FACE_BOTTOM, FACE_BOTTOM, 2'd0, 1'b0, 3, 5, 0, 4, 2, 1);
      queue_pair(MODE_PAIR, FACE_LEFT, FACE_BACK, 2'd3, 1'b0, 1, 2, 3, 3, 1, 2);
      idx = 0;
      for (int cf = 0; cf < 3; cf++) begin
         for (int nf = 0; nf < 3; nf++) begin
            queue_pair(idx[0], 3'(2 * cf), 3'(2 * nf + 1), 2'(idx), idx[2],
                       level_type'(5 + idx), 1, 9, 2, level_type'(7 - idx / 2), 4);
            idx++;
         end
      end
      for (int off = 0; off < 4; off++)
         queue_pair(MODE_PAIR, FACE_RIGHT, FACE_TOP, 2'(off), 1'b1, 6, 2, 10, 1, 8, 3);
      // sender pause until the directed pairs are all back
      wait_drained();

      // long receiver hold while the sender keeps offering
      hold_asks++;
      for (int k = 0; k < 40; k++)
         queue_random_pair();
      wait_drained();

      for (int chunk = 0; chunk < 10; chunk++) begin
         for (int k = 0; k < 149; k++)
            queue_random_pair();
         if (chunk % 3 == 2)
            wait_drained();
      end
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("checked %0d balanced pairs: %0d one-sided, %0d with an unused face code,",
               results_checked, one_sided_count, void_face_count);
      $display("%0d results with changed levels, %0d mismatches", changed_count,
               mismatch_count);
      if (mismatch_count == 0 && balance_expect.size() == 0)
         $display("tb_hex_refinement_level_balance passed");
      else
         $display("tb_hex_refinement_level_balance failed");
      $finish;
   end

endmodule
